// ===== hdl/lmss_pkg.sv =====
// Shared types, constants and codes for the LED matrix scroll scanner.
// No dependencies; every other file of the block uses this package.
package lmss_pkg;

	localparam int MAX_COLUMNS_DEF  = 64;
	localparam int MS_PER_FRAME_DEF = 24;
	localparam int QUEUE_DEPTH      = 4;

	localparam int        LEN_W         = 7;
	localparam int        DELAY_W       = 16;
	localparam int        ELAPSED_W     = 17;
	localparam logic [LEN_W-1:0]   LEN_RESET   = 7'd8;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd240;

	localparam logic [7:0] COL_MSB     = 8'h80;
	localparam logic [7:0] IDLE_SELECT = 8'hFF;
	localparam logic [7:0] BLANK_DATA  = 8'h00;

	// configuration register indexes
	localparam logic REG_IMAGE_LENGTH = 1'b0;
	localparam logic REG_SCROLL_DELAY = 1'b1;

	typedef struct packed {
		logic [LEN_W-1:0]   image_length;
		logic [DELAY_W-1:0] scroll_delay;
	} cfg_t;

	typedef struct packed {
		logic       tick;
		logic [5:0] idx;
		logic [7:0] data;
	} item_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic [2:0] col;
	} load_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_REDUCE,
		BK_HAND
	} bk_state_t;

endpackage

// ===== hdl/lmss_front.sv =====
// Front stage: accept requests, drop writes beyond the store, register the rest.
// Depends on lmss_pkg.
module lmss_front #(
	parameter int MAX_COLUMNS = lmss_pkg::MAX_COLUMNS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            func,
	input  logic [5:0]      write_index,
	input  logic [7:0]      write_data,
	output logic            push,
	output lmss_pkg::item_t push_item,
	input  logic            full
);

	logic            valid_s1;
	lmss_pkg::item_t item_s1;
	logic            accept;
	logic            keep;

	assign in_stall  = valid_s1 && full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !full;
	assign push_item = item_s1;
	// ticks always go on; a write only if its column exists
	assign keep      = func || (32'(write_index) < 32'(MAX_COLUMNS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.tick <= func;
			item_s1.idx  <= write_index;
			item_s1.data <= write_data;
		end
	end

endmodule

// ===== hdl/lmss_fifo.sv =====
// Short request queue between front and back stages.
// Depends on lmss_pkg.
module lmss_fifo #(
	parameter int DEPTH = lmss_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lmss_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output lmss_pkg::item_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	lmss_pkg::item_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		next_ptr = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/lmss_back.sv =====
// Back stage: image store, window address reduction, scroll timing.
// Depends on lmss_pkg; feeds lmss_ser through a load_t request.
module lmss_back #(
	parameter int MAX_COLUMNS  = lmss_pkg::MAX_COLUMNS_DEF,
	parameter int MS_PER_FRAME = lmss_pkg::MS_PER_FRAME_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lmss_pkg::cfg_t  cfg,
	input  lmss_pkg::item_t q_item,
	input  logic            q_empty,
	output logic            q_pop,
	output lmss_pkg::load_t ld,
	input  logic            ld_ready
);

	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int LW = ($clog2(MAX_COLUMNS + 1) > lmss_pkg::LEN_W) ?
		$clog2(MAX_COLUMNS + 1) : lmss_pkg::LEN_W;
	localparam int SW = LW + 1;
	localparam int EW = lmss_pkg::ELAPSED_W;

	lmss_pkg::bk_state_t state_q, state_d;

	logic [7:0]    mem_q [MAX_COLUMNS];
	logic [2:0]    col_q;
	logic [AW-1:0] offset_q;
	logic [EW-1:0] elapsed_q;
	logic [SW-1:0] sum_q;
	logic          blank_q;
	logic [2:0]    col_s_q;
	logic [7:0]    rd_q;

	logic [LW-1:0] len_ext, eff_len;
	logic [SW-1:0] len_sum;
	logic          scroll;
	logic          wr_en, tick_take, rd_en, sub_en, fits;
	logic [EW-1:0] elapsed_add;
	logic          advance;
	logic [AW:0]   offset_inc;
	logic [AW-1:0] offset_wrap;

	assign len_ext = LW'(cfg.image_length);
	assign eff_len = (len_ext > LW'(MAX_COLUMNS)) ? LW'(MAX_COLUMNS) : len_ext;
	assign len_sum = SW'(eff_len);
	assign scroll  = (eff_len > LW'(8));
	assign fits    = blank_q || (sum_q < len_sum);

	assign elapsed_add = elapsed_q + EW'(MS_PER_FRAME);
	assign advance     = (elapsed_add >= EW'(cfg.scroll_delay));
	assign offset_inc  = {1'b0, offset_q} + (AW + 1)'(1);
	assign offset_wrap = (SW'(offset_inc) >= len_sum) ? '0 : offset_inc[AW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			lmss_pkg::BK_IDLE: begin
				if (!q_empty && q_item.tick) state_d = lmss_pkg::BK_REDUCE;
			end
			lmss_pkg::BK_REDUCE: begin
				if (fits) state_d = lmss_pkg::BK_HAND;
			end
			lmss_pkg::BK_HAND: begin
				if (ld_ready) state_d = lmss_pkg::BK_IDLE;
			end
			default: state_d = lmss_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		rd_en    = 1'b0;
		sub_en   = 1'b0;
		ld.valid = 1'b0;
		case (state_q)
			lmss_pkg::BK_IDLE: begin
				q_pop = !q_empty;
			end
			lmss_pkg::BK_REDUCE: begin
				rd_en  = fits;
				sub_en = !fits;
			end
			lmss_pkg::BK_HAND: begin
				ld.valid = 1'b1;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
		ld.data = blank_q ? lmss_pkg::BLANK_DATA : rd_q;
		ld.col  = col_s_q;
	end

	assign wr_en     = q_pop && !q_item.tick;
	assign tick_take = q_pop && q_item.tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lmss_pkg::BK_IDLE;
			col_q     <= '0;
			offset_q  <= '0;
			elapsed_q <= '0;
		end else begin
			state_q <= state_d;
			if (tick_take) begin
				col_q <= col_q + 3'd1;
				// end of a frame of a scrolling image: accumulate time, advance the window when due
				if (col_q == 3'd7 && scroll) begin
					if (advance) begin
						offset_q  <= offset_wrap;
						elapsed_q <= '0;
					end else begin
						elapsed_q <= elapsed_add;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_take) begin
			sum_q   <= scroll ? SW'(offset_q) + SW'(col_q) : SW'(col_q);
			blank_q <= !scroll && (LW'(col_q) >= eff_len);
			col_s_q <= col_q;
		end else if (sub_en) begin
			sum_q <= sum_q - len_sum;
		end
		if (wr_en) begin
			mem_q[AW'(q_item.idx)] <= q_item.data;
		end
		if (rd_en) begin
			rd_q <= mem_q[sum_q[AW-1:0]];
		end
	end

endmodule

// ===== hdl/lmss_ser.sv =====
// Output serializer: shift one column out MSB first, latch and select on the eighth bit.
// Depends on lmss_pkg.
module lmss_ser (
	input  logic            clk,
	input  logic            arst_n,
	input  lmss_pkg::load_t ld,
	output logic            ld_ready,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            serial_bit,
	output logic [7:0]      column_select,
	output logic            last
);

	logic       busy_q;
	logic [2:0] cnt_q;
	logic [7:0] sh_q;
	logic [2:0] col_q;
	logic       take, fin, load;

	assign take     = busy_q && !out_stall;
	assign fin      = take && (cnt_q == 3'd7);
	assign ld_ready = !busy_q || fin;
	assign load     = ld.valid && ld_ready;

	assign out_valid     = busy_q;
	assign serial_bit    = sh_q[7];
	assign last          = (cnt_q == 3'd7);
	assign column_select = last ? ~(lmss_pkg::COL_MSB >> col_q) : lmss_pkg::IDLE_SELECT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (take) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= ld.data;
			col_q <= ld.col;
		end else if (take) begin
			sh_q <= {sh_q[6:0], 1'b0};
		end
	end

endmodule

// ===== hdl/led_matrix_scroll_scanner_unit.sv =====
// LED matrix scroll scanner, top level: configuration registers and stage wiring.
// Depends on lmss_pkg, lmss_front, lmss_fifo, lmss_back and lmss_ser.
//
// Drives an 8-column LED matrix through a serial shift register. A request with
// func = 0 loads write_data into image column write_index (indexes at or beyond
// MAX_COLUMNS are dropped) and produces no output. A request with func = 1 is a
// display tick: it produces eight output bits, row bit 7 first; the eighth has
// last = 1 and carries the active-low column_select, the other seven hold 0xFF.
// Images of up to eight columns show as is, blank past their length; longer ones
// show a window that starts at the scroll offset and wraps, and the window moves
// one column once MS_PER_FRAME per frame adds up to the scroll delay. Timing: a
// tick gives eight output bits, one per cycle while out_stall is low, paced by
// the serializer; the back stage retires a write as it pops it. The back stage
// takes a tick through idle, reduce and hand states and in reduce subtracts the
// image length to wrap the window address, at most once unless the offset sits
// past a shortened image. It works on the next tick while the serializer shifts,
// so unstalled ticks stream without gaps; only six or more subtractions, which
// need an offset far past a shortened image, open a gap. A four-entry queue
// sits between front and back, so input flows on while output stalls, until full.
// Configuration: index 0 is image_length (cfg_data[6:0]), index 1 is the scroll
// delay in ms (cfg_data[15:0]); write only while the block is idle. The image
// store has no reset and needs no clearing pass: show only columns written.
module led_matrix_scroll_scanner_unit #(
	parameter int MAX_COLUMNS  = lmss_pkg::MAX_COLUMNS_DEF,
	parameter int MS_PER_FRAME = lmss_pkg::MS_PER_FRAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [5:0]  write_index,
	input  logic [7:0]  write_data,
	// serial output
	output logic        out_valid,
	input  logic        out_stall,
	output logic        serial_bit,
	output logic [7:0]  column_select,
	output logic        last,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	lmss_pkg::cfg_t  cfg_q;
	logic            push, full, pop, empty;
	lmss_pkg::item_t push_item, head;
	lmss_pkg::load_t ld;
	logic            ld_ready;

	// register writes are always accepted: cfg_ready is tied high
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_length <= lmss_pkg::LEN_RESET;
			cfg_q.scroll_delay <= lmss_pkg::DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lmss_pkg::REG_IMAGE_LENGTH: begin
					cfg_q.image_length <= cfg_data[lmss_pkg::LEN_W-1:0];
				end
				lmss_pkg::REG_SCROLL_DELAY: begin
					cfg_q.scroll_delay <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// front: accept and classify requests
	lmss_front #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.write_index(write_index),
		.write_data (write_data),
		.push       (push),
		.push_item  (push_item),
		.full       (full)
	);

	// hold requests in order between front and back
	lmss_fifo #(
		.DEPTH(lmss_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	// back: store columns, resolve window address, advance scroll
	lmss_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MS_PER_FRAME(MS_PER_FRAME)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_item  (head),
		.q_empty (empty),
		.q_pop   (pop),
		.ld      (ld),
		.ld_ready(ld_ready)
	);

	// shift each column out, one bit per cycle while out_stall is low
	lmss_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.ld           (ld),
		.ld_ready     (ld_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.serial_bit   (serial_bit),
		.column_select(column_select),
		.last         (last)
	);

	// a column, once started, streams without gaps until its last bit
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last && !out_stall |=> out_valid)
		else $error("column stream broke before its last bit");

	// exactly one column driven on the last bit, none before
	a_select: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last ? $onehot(~column_select) : (column_select == 8'hFF)))
		else $error("column select pattern wrong for bit position");

	// the queue never takes a request while full, nor gives one while empty
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("request queue overflow or underflow");

endmodule

// ===== dv/led_matrix_scroll_scanner_unit_tb.sv =====
// Self-checking testbench for led_matrix_scroll_scanner_unit.
// Depends on lmss_pkg and the RTL of the scanner; needs no files or arguments.
// Predicts every serial bit, checks it in order, and varies config and traffic.
module led_matrix_scroll_scanner_unit_tb;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;
	localparam int   QUIET_LIMIT = 4000;
	localparam int   SETTLE      = 32;
	localparam int   NCOL        = lmss_pkg::MAX_COLUMNS_DEF;
	localparam int   EW          = lmss_pkg::ELAPSED_W;

	// one predicted shift-register bit
	typedef struct packed {
		logic       row_bit;
		logic [7:0] sel;
		logic       is_last;
	} row_bit_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        func = 1'b0;
	logic [5:0]  write_index = '0;
	logic [7:0]  write_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        serial_bit;
	logic [7:0]  column_select;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	// requests waiting for the driver, and the bits the scanner still owes us
	lmss_pkg::item_t pending_q[$];
	row_bit_t        row_bit_q[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int quiet_cycles = 0;

	// shadow of the scanner state
	logic [7:0]                   image_copy[NCOL];
	logic [5:0]                   win_offset = '0;
	logic [2:0]                   scan_col = '0;
	logic [EW-1:0]                frame_ms = '0;
	logic [lmss_pkg::LEN_W-1:0]   cfg_len = lmss_pkg::LEN_RESET;
	logic [lmss_pkg::DELAY_W-1:0] cfg_delay = lmss_pkg::DELAY_RESET;

	lmss_pkg::item_t nxt;
	row_bit_t        want;

	led_matrix_scroll_scanner_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.write_index   (write_index),
		.write_data    (write_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.serial_bit    (serial_bit),
		.column_select (column_select),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Work out the eight bits of one display tick and advance the scan state.
	// Short images (eight columns or fewer, zero included) show blank past their
	// length and never scroll; longer ones show a wrapping window, and the window
	// moves once the frame time reaches the delay (a zero delay moves every frame,
	// a lowered delay moves at the end of the next frame).
	task automatic shift_out_column();
		int         len;
		logic [7:0] pattern;
		row_bit_t   b;
		len = (cfg_len > NCOL) ? NCOL : int'(cfg_len);
		if (len <= 8)
			pattern = (scan_col < len) ? image_copy[scan_col] : lmss_pkg::BLANK_DATA;
		else
			pattern = image_copy[(win_offset + scan_col) % len];
		for (int k = 0; k < 8; k++) begin
			b.row_bit = pattern[7 - k];
			b.sel     = (k == 7) ? ~(lmss_pkg::COL_MSB >> scan_col) : lmss_pkg::IDLE_SELECT;
			b.is_last = (k == 7);
			row_bit_q.push_back(b);
		end
		if (scan_col == 3'd7 && len > 8) begin
			frame_ms = frame_ms + EW'(lmss_pkg::MS_PER_FRAME_DEF);
			if (frame_ms >= cfg_delay) begin
				// an offset left past a shortened image wraps to zero here
				win_offset = (win_offset + 1 >= len) ? 6'd0 : win_offset + 6'd1;
				frame_ms   = '0;
			end
		end
		scan_col = scan_col + 3'd1;
	endtask

	// Driver: predict on acceptance, hold a stalled request, otherwise pull the
	// next one from the queue unless the sender idles this cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (func == FUNC_TICK)
					shift_out_column();
				else
					image_copy[write_index] = write_data;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pending_q.pop_front();
					in_valid    <= 1'b1;
					func        <= nxt.tick;
					write_index <= nxt.idx;
					write_data  <= nxt.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random and compare each accepted bit with the oldest
	// prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if (out_valid && !out_stall) begin
				if (row_bit_q.size() == 0) begin
					$error("unexpected output: serial_bit %0d column_select %h last %0d",
						serial_bit, column_select, last);
					errors++;
				end else begin
					want = row_bit_q.pop_front();
					if (serial_bit !== want.row_bit) begin
						$error("serial_bit: expected %0d, got %0d", want.row_bit, serial_bit);
						errors++;
					end
					if (column_select !== want.sel) begin
						$error("column_select: expected %h, got %h", want.sel, column_select);
						errors++;
					end
					if (last !== want.is_last) begin
						$error("last: expected %0d, got %0d", want.is_last, last);
						errors++;
					end
				end
			end
		end
	end

	// count cycles in which no channel moves anything
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic queue_item(input logic f, input logic [5:0] idx, input logic [7:0] data);
		lmss_pkg::item_t it;
		it.tick = f;
		it.idx  = idx;
		it.data = data;
		pending_q.push_back(it);
	endtask

	// Column contents for the initial load: fixed patterns at both ends of the
	// index range (data extremes at the low end), random elsewhere.
	function automatic logic [7:0] load_pattern(input int i);
		case (i)
			0:        load_pattern = 8'hFF;
			1:        load_pattern = lmss_pkg::BLANK_DATA;
			2:        load_pattern = lmss_pkg::COL_MSB;
			3:        load_pattern = 8'h01;
			NCOL - 1: load_pattern = 8'hA5;
			default:  load_pattern = 8'($urandom_range(255));
		endcase
	endfunction

	// Queue n random requests, write_pct percent of them column loads.
	task automatic load_random(input int n, input int write_pct);
		@(negedge clk);
		repeat (n) begin
			queue_item(($urandom_range(99) < write_pct) ? FUNC_WRITE : FUNC_TICK,
				6'($urandom_range(63)), 8'($urandom_range(255)));
		end
	endtask

	// Wait for every request to go in and every bit to come out, then give the
	// back stage time to retire trailing column loads before touching config.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || in_valid || row_bit_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write one config register and mirror it once the handshake completes.
	task automatic write_reg(input logic idx, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == lmss_pkg::REG_IMAGE_LENGTH)
			cfg_len = value[lmss_pkg::LEN_W-1:0];
		else
			cfg_delay = value[lmss_pkg::DELAY_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Load every image column first so no tick ever reads an unwritten entry.
		@(negedge clk);
		for (int i = 0; i < NCOL; i++)
			queue_item(FUNC_WRITE, 6'(i), load_pattern(i));
		wait_drained();

		// Reset config: the first columns show as loaded.
		@(negedge clk);
		repeat (4) queue_item(FUNC_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)));
		wait_drained();

		// Zero length shows nothing; zero delay must not move a short image.
		write_reg(lmss_pkg::REG_IMAGE_LENGTH, {9'($urandom_range(511)), 7'd0});
		write_reg(lmss_pkg::REG_SCROLL_DELAY, 16'd0);
		@(negedge clk);
		repeat (4) queue_item(FUNC_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)));
		wait_drained();

		// Short image: blank past the third column.
		write_reg(lmss_pkg::REG_IMAGE_LENGTH, {9'($urandom_range(511)), 7'd3});
		@(negedge clk);
		repeat (4) queue_item(FUNC_TICK, 6'($urandom_range(63)), 8'($urandom_range(255)));
		wait_drained();

		// Length above the store clamps; zero delay scrolls every frame, no idling.
		// Twelve ticks so far, so these 68 ticks hold nine frame ends: offset nine.
		write_reg(lmss_pkg::REG_IMAGE_LENGTH, {9'($urandom_range(511)), 7'd127});
		load_random(68, 0);
		wait_drained();

		// Shrink the image under that offset: window start and advance must wrap.
		send_idle_pct = 88;
		write_reg(lmss_pkg::REG_IMAGE_LENGTH, {9'($urandom_range(511)), 7'd9});
		load_random(12, 25);
		wait_drained();

		// Longest delay builds up frame time without scrolling.
		send_idle_pct  = 0;
		recv_stall_pct = 88;
		write_reg(lmss_pkg::REG_IMAGE_LENGTH, {9'($urandom_range(511)), 7'd20});
		write_reg(lmss_pkg::REG_SCROLL_DELAY, 16'hFFFF);
		load_random(8, 25);
		wait_drained();

		// Drop the delay to one frame's time: advance at the next frame end.
		send_idle_pct  = 24;
		recv_stall_pct = 24;
		write_reg(lmss_pkg::REG_SCROLL_DELAY, 16'd24);
		load_random(8, 25);
		wait_drained();

		// Smallest non-empty image and a delay of one ms.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_reg(lmss_pkg::REG_IMAGE_LENGTH, {9'($urandom_range(511)), 7'd1});
		write_reg(lmss_pkg::REG_SCROLL_DELAY, 16'd1);
		load_random(8, 25);
		wait_drained();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
